>>> sv/smt_phys_reg_admission_assert.svh
// Assertion macros shared by the register admission block.
`ifndef SMT_PHYS_REG_ADMISSION_ASSERT_SVH
`define SMT_PHYS_REG_ADMISSION_ASSERT_SVH

// Combinational implication checked on every rising clock edge outside reset.
`define SPRA_ASSERT_IMP(lbl, clkx, rstx, ante, cons) \
  lbl: assert property (@(posedge clkx) disable iff (rstx) (ante) |-> (cons)) \
    else $error("spra implication check failed");

// Next-cycle implication checked outside reset.
`define SPRA_ASSERT_NXT(lbl, clkx, rstx, ante, cons) \
  lbl: assert property (@(posedge clkx) disable iff (rstx) (ante) |=> (cons)) \
    else $error("spra next-cycle check failed");

// Condition that must hold in the cycle after reset is seen.
`define SPRA_ASSERT_RST(lbl, clkx, rstx, cons) \
  lbl: assert property (@(posedge clkx) (rstx) |=> (cons)) \
    else $error("spra post-reset check failed");

`endif

>>> sv/spra_pkg.sv
// Shared types, constants and tables for the register admission block.
package spra_pkg;

  localparam int MAX_THREADS = 4;
  localparam int SLOT_COUNT  = 4;
  localparam int REG_BITS    = 10;
  localparam int NEED_BITS   = 4;
  localparam int TID_BITS    = 2;
  localparam int CNT_BITS    = 3;
  localparam int PCT_BITS    = 7;
  localparam int POL_BITS    = 2;

  // Queue depth shared by the front and result queues.
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = 1;

  // Share = cap * ceil(2^13 / a) >> 13 is exact for 10-bit cap and a up to 7.
  localparam int SHARE_SHIFT = 13;
  localparam int SHARE_ONE   = 1 << SHARE_SHIFT;
  localparam int RECIP_BITS  = SHARE_SHIFT + 1;
  localparam logic [RECIP_BITS-1:0] RECIP [8] = '{
    RECIP_BITS'(SHARE_ONE),
    RECIP_BITS'(SHARE_ONE),
    RECIP_BITS'(SHARE_ONE / 2),
    RECIP_BITS'((SHARE_ONE + 2) / 3),
    RECIP_BITS'(SHARE_ONE / 4),
    RECIP_BITS'((SHARE_ONE + 4) / 5),
    RECIP_BITS'((SHARE_ONE + 5) / 6),
    RECIP_BITS'((SHARE_ONE + 6) / 7)
  };

  // Quota = (share * percent) * ceil(2^24 / 100) >> 24, exact for 17-bit products.
  localparam int PERCENT_DIV    = 100;
  localparam int QUOTA_SHIFT    = 24;
  localparam int QUOTA_MUL      = ((1 << QUOTA_SHIFT) + PERCENT_DIV - 1) / PERCENT_DIV;
  localparam int QUOTA_MUL_BITS = 18;
  localparam int QUOTA_BITS     = REG_BITS + 1;

  // Slots that exist in this configuration.
  localparam logic [SLOT_COUNT-1:0] LIVE_MASK = SLOT_COUNT'((1 << MAX_THREADS) - 1);

  typedef logic [REG_BITS-1:0] reg_t;

  typedef enum logic [POL_BITS-1:0] {
    POL_DYNAMIC = 2'd0,
    POL_STATIC  = 2'd1,
    POL_BORROW  = 2'd2
  } policy_t;

  typedef enum logic [1:0] {
    REG_POLICY  = 2'd0,
    REG_PERCENT = 2'd1,
    REG_FIXED   = 2'd2,
    REG_TCOUNT  = 2'd3
  } reg_idx_t;

  // Configuration register values seen by the back end.
  typedef struct packed {
    logic [POL_BITS-1:0] policy;
    logic [PCT_BITS-1:0] percent;
    reg_t                fixed_base;
    logic [CNT_BITS-1:0] tcount;
  } cfg_t;

  // One query with the fields derived by the front end.
  typedef struct packed {
    logic [TID_BITS-1:0]   tid;
    reg_t                  cap;
    reg_t                  freeq;
    logic [NEED_BITS-1:0]  need;
    reg_t [SLOT_COUNT-1:0] used;
    logic [SLOT_COUNT-1:0] donors;
    logic [SLOT_COUNT-1:0] active;
    logic [CNT_BITS-1:0]   act_cnt;
    logic                  any_active;
  } item_t;

  // One admission result.
  typedef struct packed {
    logic may;
    reg_t count;
    logic hit;
    reg_t blimit;
  } res_t;

endpackage

>>> sv/spra_front.sv
// Front end: classifies incoming queries and buffers them for the back end.
module spra_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  spra_pkg::item_t               in_item,
  input  logic [spra_pkg::CNT_BITS-1:0] tcount,
  output logic                          full,
  output logic                          head_valid,
  output spra_pkg::item_t               head,
  input  logic                          pop
);
  import spra_pkg::*;

  item_t                 mem [QDEPTH];
  logic [QPTR_BITS-1:0]  wptr;
  logic [QPTR_BITS-1:0]  rptr;
  logic [QPTR_BITS:0]    count;
  item_t                 cls;
  logic [SLOT_COUNT-1:0] act_live;
  logic [CNT_BITS-1:0]   pc;
  logic                  wr;
  logic                  rd;

  // Count the live active threads; fall back to the configured count, or to one when that is zero.
  always_comb begin
    act_live = in_item.active & LIVE_MASK;
    pc = '0;
    for (int t = 0; t < SLOT_COUNT; t++) begin
      pc = pc + CNT_BITS'(act_live[t]);
    end
    cls = in_item;
    cls.active = act_live;
    cls.any_active = |act_live;
    if (pc != '0) begin
      cls.act_cnt = pc;
    end else if (tcount == '0) begin
      cls.act_cnt = CNT_BITS'(1);
    end else begin
      cls.act_cnt = tcount;
    end
  end

  assign full       = (count == (QPTR_BITS + 1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rptr];
  assign wr         = push && !full;
  assign rd         = pop && head_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + QPTR_BITS'(1);
      end
      if (rd) begin
        rptr <= rptr + QPTR_BITS'(1);
      end
      if (wr && !rd) begin
        count <= count + (QPTR_BITS + 1)'(1);
      end else if (rd && !wr) begin
        count <= count - (QPTR_BITS + 1)'(1);
      end
    end
  end

endmodule

>>> sv/spra_back.sv
// Back end: six-stage pipeline that computes share, reservations and the verdict.
module spra_back (
  input  logic             clk,
  input  logic             rst,
  input  spra_pkg::cfg_t   cfg,
  input  logic             in_valid,
  input  spra_pkg::item_t  in_item,
  output logic             in_pop,
  input  logic             out_room,
  output logic             res_valid,
  output spra_pkg::res_t   res
);
  import spra_pkg::*;

  localparam int SPW = REG_BITS + RECIP_BITS;
  localparam int PPW = REG_BITS + PCT_BITS;
  localparam int QPW = PPW + QUOTA_MUL_BITS;
  localparam int SUMW = QUOTA_BITS + 2;

  logic en;

  // Stage valid bits.
  logic v1, v2, v3, v4, v5, v6;

  // Stage payloads.
  item_t                 it1, it2, it3, it4, it5;
  reg_t                  share1, share2, share3, share4;
  logic [PPW-1:0]        pprod2;
  reg_t                  base2, base3;
  logic [QUOTA_BITS-1:0] quota3;
  logic [QUOTA_BITS-1:0] term4 [SLOT_COUNT];
  reg_t                  mine4, mine5;
  reg_t                  limit5;
  reg_t                  blimit5;

  // Combinational stage results.
  logic [SPW-1:0]        sprod;
  reg_t                  share_c;
  reg_t                  base_c;
  logic [QPW-1:0]        qprod;
  logic [QUOTA_BITS-1:0] term_c [SLOT_COUNT];
  reg_t                  mine_c;
  logic [SUMW-1:0]       reserved_c;
  reg_t                  blimit_c;
  reg_t                  avail_c;
  logic [REG_BITS:0]     want_c;
  res_t                  res_c;

  // The whole pipeline advances while the result queue has room.
  assign en     = out_room;
  assign in_pop = en && in_valid;

  // Stage 1: fair share by reciprocal multiply.
  always_comb begin
    sprod   = SPW'(in_item.cap) * SPW'(RECIP[in_item.act_cnt]);
    share_c = REG_BITS'(sprod >> SHARE_SHIFT);
  end

  // Stage 2: base reserve and the quota numerator.
  always_comb begin
    if (cfg.fixed_base != '0) begin
      base_c = (cfg.fixed_base < share1) ? cfg.fixed_base : share1;
    end else begin
      base_c = (share1 > REG_BITS'(1)) ? share1 : REG_BITS'(1);
    end
  end

  // Stage 3: quota by reciprocal multiply.
  assign qprod = QPW'(pprod2) * QPW'(QUOTA_MUL);

  // Stage 4: reservation of each other active thread, and the requester's usage.
  always_comb begin
    logic [QUOTA_BITS-1:0] r;
    logic [QUOTA_BITS-1:0] u;
    for (int t = 0; t < SLOT_COUNT; t++) begin
      r = it3.donors[t] ? quota3 : QUOTA_BITS'(base3);
      u = QUOTA_BITS'(it3.used[t]);
      if (it3.any_active && it3.active[t] && (it3.tid != TID_BITS'(t))) begin
        term_c[t] = (u > r) ? u : r;
      end else begin
        term_c[t] = '0;
      end
    end
    mine_c = LIVE_MASK[it3.tid] ? it3.used[it3.tid] : '0;
  end

  // Stage 5: total reservation and the borrow limit.
  always_comb begin
    reserved_c = '0;
    for (int t = 0; t < SLOT_COUNT; t++) begin
      reserved_c = reserved_c + SUMW'(term4[t]);
    end
    if (reserved_c >= SUMW'(it4.cap)) begin
      blimit_c = '0;
    end else begin
      blimit_c = REG_BITS'(SUMW'(it4.cap) - reserved_c);
    end
  end

  // Stage 6: admission verdict under the configured policy.
  always_comb begin
    avail_c = (mine5 >= limit5) ? '0 : (limit5 - mine5);
    want_c  = (REG_BITS + 1)'(mine5) + (REG_BITS + 1)'(it5.need);
    res_c.blimit = blimit5;
    if (cfg.policy == POL_STATIC || cfg.policy == POL_BORROW) begin
      res_c.may   = (REG_BITS'(it5.need) <= it5.freeq) &&
                    (want_c <= (REG_BITS + 1)'(limit5));
      res_c.count = (avail_c < it5.freeq) ? avail_c : it5.freeq;
      res_c.hit   = (it5.freeq >= REG_BITS'(it5.need)) &&
                    (avail_c < REG_BITS'(it5.need));
    end else begin
      res_c.may   = (REG_BITS'(it5.need) <= it5.freeq);
      res_c.count = it5.freeq;
      res_c.hit   = 1'b0;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      it1     <= in_item;
      share1  <= share_c;
      it2     <= it1;
      share2  <= share1;
      base2   <= base_c;
      pprod2  <= PPW'(share1) * PPW'(cfg.percent);
      it3     <= it2;
      share3  <= share2;
      base3   <= base2;
      quota3  <= QUOTA_BITS'(qprod >> QUOTA_SHIFT);
      it4     <= it3;
      share4  <= share3;
      term4   <= term_c;
      mine4   <= mine_c;
      it5     <= it4;
      mine5   <= mine4;
      blimit5 <= blimit_c;
      limit5  <= (cfg.policy == POL_BORROW) ? blimit_c : share4;
      res     <= res_c;
    end
  end

  assign res_valid = v6 && en;

endmodule

>>> sv/spra_result_q.sv
// Result queue that holds finished admission results until they are taken.
module spra_result_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  spra_pkg::res_t wr_res,
  output logic           room,
  output logic           empty,
  output spra_pkg::res_t head,
  input  logic           pop
);
  import spra_pkg::*;

  res_t                 mem [QDEPTH];
  logic [QPTR_BITS-1:0] wptr;
  logic [QPTR_BITS-1:0] rptr;
  logic [QPTR_BITS:0]   count;
  logic                 rd;

  assign room  = (count != (QPTR_BITS + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];
  assign rd    = pop && !empty;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_res;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + QPTR_BITS'(1);
      end
      if (rd) begin
        rptr <= rptr + QPTR_BITS'(1);
      end
      if (wr && !rd) begin
        count <= count + (QPTR_BITS + 1)'(1);
      end else if (rd && !wr) begin
        count <= count - (QPTR_BITS + 1)'(1);
      end
    end
  end

endmodule

>>> sv/smt_phys_reg_admission.sv
// Top level of the SMT physical register admission check.
// A query accepted into the front queue passes through the six back-end stages into the result queue.
// Throughput: one query per cycle, set by the six-stage back-end pipeline with no loop.
// The back end stalls as a whole only while the two-entry result queue is full.
// Reset (synchronous, active high) empties both queues and restores the register defaults.
module smt_phys_reg_admission (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  thread_id,
  input  logic [9:0]  class_capacity,
  input  logic [9:0]  free_count,
  input  logic [3:0]  count_needed,
  input  logic [9:0]  used_thread0,
  input  logic [9:0]  used_thread1,
  input  logic [9:0]  used_thread2,
  input  logic [9:0]  used_thread3,
  input  logic [3:0]  donor_mask,
  input  logic [3:0]  active_mask,
  output logic        empty,
  input  logic        pop,
  output logic        may_allocate,
  output logic [9:0]  allocatable_count,
  output logic        thread_limit_hit,
  output logic [9:0]  borrow_limit
);
  import spra_pkg::*;

  `include "smt_phys_reg_admission_assert.svh"

  cfg_t     cfg;
  reg_idx_t widx;
  logic     cfg_wr;
  item_t    in_item;
  item_t    mid_head;
  logic     mid_valid;
  logic     mid_pop;
  logic     out_room;
  logic     back_valid;
  res_t     back_res;
  res_t     head_res;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy     <= POL_DYNAMIC;
      cfg.percent    <= '0;
      cfg.fixed_base <= '0;
      cfg.tcount     <= CNT_BITS'(1);
    end else if (cfg_wr) begin
      case (widx)
        REG_POLICY:  cfg.policy     <= pwdata[POL_BITS-1:0];
        REG_PERCENT: cfg.percent    <= pwdata[PCT_BITS-1:0];
        REG_FIXED:   cfg.fixed_base <= pwdata[REG_BITS-1:0];
        REG_TCOUNT:  cfg.tcount     <= pwdata[CNT_BITS-1:0];
        default:     cfg.policy     <= cfg.policy;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (widx)
      REG_POLICY:  prdata = 32'(cfg.policy);
      REG_PERCENT: prdata = 32'(cfg.percent);
      REG_FIXED:   prdata = 32'(cfg.fixed_base);
      REG_TCOUNT:  prdata = 32'(cfg.tcount);
      default:     prdata = '0;
    endcase
  end

  // Gather the query fields; the front end fills in the derived fields.
  always_comb begin
    in_item            = '0;
    in_item.tid        = thread_id;
    in_item.cap        = class_capacity;
    in_item.freeq      = free_count;
    in_item.need       = count_needed;
    in_item.used[0]    = used_thread0;
    in_item.used[1]    = used_thread1;
    in_item.used[2]    = used_thread2;
    in_item.used[3]    = used_thread3;
    in_item.donors     = donor_mask;
    in_item.active     = active_mask;
  end

  spra_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_item    (in_item),
    .tcount     (cfg.tcount),
    .full       (full),
    .head_valid (mid_valid),
    .head       (mid_head),
    .pop        (mid_pop)
  );

  spra_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mid_valid),
    .in_item   (mid_head),
    .in_pop    (mid_pop),
    .out_room  (out_room),
    .res_valid (back_valid),
    .res       (back_res)
  );

  spra_result_q u_result_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (back_valid),
    .wr_res (back_res),
    .room   (out_room),
    .empty  (empty),
    .head   (head_res),
    .pop    (pop)
  );

  assign may_allocate      = head_res.may;
  assign allocatable_count = head_res.count;
  assign thread_limit_hit  = head_res.hit;
  assign borrow_limit      = head_res.blimit;

  // Reset leaves both queues empty.
  `SPRA_ASSERT_RST(a_reset_empty, clk, rst, empty && !full)
  // A thread limit block and an admission grant exclude each other.
  `SPRA_ASSERT_IMP(a_hit_excl, clk, rst, !empty, !(may_allocate && thread_limit_hit))
  // A thread limit block means fewer registers remain than the largest request can need.
  `SPRA_ASSERT_IMP(a_hit_count, clk, rst, !empty && thread_limit_hit, allocatable_count < 10'd15)
  // A waiting result stays until it is taken.
  `SPRA_ASSERT_NXT(a_result_held, clk, rst, !empty && !pop, !empty)

endmodule

>>> tb/tb_smt_phys_reg_admission.sv
// Self-checking testbench for the SMT physical register admission check.
module tb_smt_phys_reg_admission;
  import spra_pkg::*;

  // The policy encoding that the block treats as dynamic.
  localparam logic [POL_BITS-1:0] POL_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;

  // One admission query as driven onto the input ports.
  typedef struct packed {
    logic [TID_BITS-1:0]   tid;
    reg_t                  cap;
    reg_t                  freeq;
    logic [NEED_BITS-1:0]  need;
    reg_t [SLOT_COUNT-1:0] used;
    logic [SLOT_COUNT-1:0] donors;
    logic [SLOT_COUNT-1:0] active;
  } query_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        push;
  logic        full;
  logic [1:0]  thread_id;
  logic [9:0]  class_capacity;
  logic [9:0]  free_count;
  logic [3:0]  count_needed;
  logic [9:0]  used_thread0;
  logic [9:0]  used_thread1;
  logic [9:0]  used_thread2;
  logic [9:0]  used_thread3;
  logic [3:0]  donor_mask;
  logic [3:0]  active_mask;
  logic        empty;
  logic        pop = 1'b0;
  logic        may_allocate;
  logic [9:0]  allocatable_count;
  logic        thread_limit_hit;
  logic [9:0]  borrow_limit;

  // Testbench copy of the configuration registers, at their reset values.
  logic [POL_BITS-1:0] cfg_policy = POL_DYNAMIC;
  logic [PCT_BITS-1:0] cfg_percent = '0;
  reg_t                cfg_fixed = '0;
  logic [CNT_BITS-1:0] cfg_tcount = CNT_BITS'(1);

  res_t pending_verdicts[$];
  int   mismatches = 0;
  int   results_checked = 0;
  int   queries_sent = 0;
  int   settings_used = 1;
  int   cycles = 0;
  bit   idle_on = 1'b1;

  smt_phys_reg_admission i_dut (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .push              (push),
    .full              (full),
    .thread_id         (thread_id),
    .class_capacity    (class_capacity),
    .free_count        (free_count),
    .count_needed      (count_needed),
    .used_thread0      (used_thread0),
    .used_thread1      (used_thread1),
    .used_thread2      (used_thread2),
    .used_thread3      (used_thread3),
    .donor_mask        (donor_mask),
    .active_mask       (active_mask),
    .empty             (empty),
    .pop               (pop),
    .may_allocate      (may_allocate),
    .allocatable_count (allocatable_count),
    .thread_limit_hit  (thread_limit_hit),
    .borrow_limit      (borrow_limit)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Computes the admission verdict for one query under the current settings.
  function automatic res_t predict_admission(query_t q);
    res_t        r;
    int unsigned n_active;
    int unsigned divisor;
    int unsigned share;
    int unsigned base;
    int unsigned quota;
    int unsigned reserved;
    int unsigned hold;
    int unsigned blimit;
    int unsigned limit;
    int unsigned mine;
    int unsigned avail;
    n_active = 0;
    reserved = 0;
    for (int t = 0; t < SLOT_COUNT; t++) begin
      if (q.active[t]) n_active++;
    end
    if (n_active != 0) divisor = n_active;
    else divisor = (cfg_tcount == 0) ? 1 : cfg_tcount;
    share = q.cap / divisor;
    if (cfg_fixed != 0) base = (cfg_fixed < share) ? cfg_fixed : share;
    else base = (share > 1) ? share : 1;
    quota = share * cfg_percent / 100;

    // Every other active thread keeps the larger of its usage and its reserve.
    for (int t = 0; t < SLOT_COUNT; t++) begin
      if (q.active[t] && t != q.tid) begin
        hold = q.donors[t] ? quota : base;
        reserved += (q.used[t] > hold) ? q.used[t] : hold;
      end
    end
    blimit = (reserved >= q.cap) ? 0 : q.cap - reserved;
    mine = q.used[q.tid];

    if (cfg_policy == POL_STATIC || cfg_policy == POL_BORROW) begin
      limit = (cfg_policy == POL_BORROW) ? blimit : share;
      avail = (mine >= limit) ? 0 : limit - mine;
      r.may = (q.need <= q.freeq) && (mine + q.need <= limit);
      r.count = reg_t'((avail < q.freeq) ? avail : q.freeq);
      r.hit = (q.freeq >= q.need) && (avail < q.need);
    end else begin
      r.may = (q.need <= q.freeq);
      r.count = q.freeq;
      r.hit = 1'b0;
    end
    r.blimit = reg_t'(blimit);
    return r;
  endfunction

  function automatic query_t make_query(int unsigned tid, int unsigned cap, int unsigned freeq,
                                        int unsigned need, int unsigned u0, int unsigned u1,
                                        int unsigned u2, int unsigned u3, int unsigned donors,
                                        int unsigned active);
    query_t q;
    q.tid = TID_BITS'(tid);
    q.cap = reg_t'(cap);
    q.freeq = reg_t'(freeq);
    q.need = NEED_BITS'(need);
    q.used[0] = reg_t'(u0);
    q.used[1] = reg_t'(u1);
    q.used[2] = reg_t'(u2);
    q.used[3] = reg_t'(u3);
    q.donors = SLOT_COUNT'(donors);
    q.active = SLOT_COUNT'(active);
    return q;
  endfunction

  // Mostly plausible occupancy; a fifth of the queries use the whole field ranges.
  function automatic query_t random_query();
    query_t      q;
    int unsigned top;
    q.tid = TID_BITS'($urandom_range(0, 3));
    q.need = NEED_BITS'($urandom_range(0, 15));
    q.donors = SLOT_COUNT'($urandom_range(0, 15));
    q.active = SLOT_COUNT'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 2) begin
      q.cap = reg_t'($urandom_range(0, 1023));
      q.freeq = reg_t'($urandom_range(0, 1023));
      for (int t = 0; t < SLOT_COUNT; t++) q.used[t] = reg_t'($urandom_range(0, 1023));
    end else begin
      q.cap = reg_t'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                  : $urandom_range(1, 1023));
      top = q.cap / 2 + 2;
      for (int t = 0; t < SLOT_COUNT; t++) q.used[t] = reg_t'($urandom_range(0, top));
      q.freeq = reg_t'($urandom_range(0, q.cap));
    end
    return q;
  endfunction

  // Sends one query and records its expected verdict on acceptance.
  task automatic send_query(query_t q);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push <= 1'b1;
    thread_id <= q.tid;
    class_capacity <= q.cap;
    free_count <= q.freeq;
    count_needed <= q.need;
    used_thread0 <= q.used[0];
    used_thread1 <= q.used[1];
    used_thread2 <= q.used[2];
    used_thread3 <= q.used[3];
    donor_mask <= q.donors;
    active_mask <= q.active;
    do @(posedge clk); while (full);
    pending_verdicts.push_back(predict_admission(q));
    queries_sent++;
  endtask

  // Stops sending and waits until every outstanding verdict has been checked.
  task automatic drain_pending();
    push <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: a setup phase followed by an access phase.
  task automatic apb_write(reg_idx_t idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_POLICY:  cfg_policy = value[POL_BITS-1:0];
      REG_PERCENT: cfg_percent = value[PCT_BITS-1:0];
      REG_FIXED:   cfg_fixed = value[REG_BITS-1:0];
      REG_TCOUNT:  cfg_tcount = value[CNT_BITS-1:0];
      default:     ;
    endcase
  endtask

  // Rewrites all four registers once the block has gone quiet.
  task automatic set_config(logic [POL_BITS-1:0] pol, int unsigned pct, int unsigned fixed,
                            int unsigned tcnt);
    drain_pending();
    apb_write(REG_POLICY, pol);
    apb_write(REG_PERCENT, pct);
    apb_write(REG_FIXED, fixed);
    apb_write(REG_TCOUNT, tcnt);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings_used++;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: random pop stalls, and each transaction checked against the oldest verdict.
  always @(posedge clk) begin : result_checker
    res_t want;
    int   stall_left;
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_verdicts.size() == 0) begin
          $error("Admission result arrived with no query outstanding");
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          check_field("may_allocate", want.may, may_allocate);
          check_field("allocatable_count", want.count, allocatable_count);
          check_field("thread_limit_hit", want.hit, thread_limit_hit);
          check_field("borrow_limit", want.blimit, borrow_limit);
          results_checked++;
        end
      end
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
      pop <= (stall_left == 0);
    end
  end

  // Reset values: dynamic policy with a thread count of one.
  task automatic test_reset_defaults();
    send_query(make_query(0, 1, 0, 15, 0, 0, 0, 0, 0, 0));
    send_query(make_query(3, 1023, 1023, 15, 1023, 1023, 1023, 1023, 15, 15));
    send_query(make_query(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Static partition: limit at the share, inactive requester, no active thread.
  task automatic test_static_partition();
    set_config(POL_STATIC, 0, 0, 4);
    send_query(make_query(0, 100, 50, 1, 25, 3, 4, 5, 0, 15));
    send_query(make_query(2, 100, 80, 15, 1, 2, 10, 3, 0, 3));
    send_query(make_query(1, 100, 100, 15, 0, 20, 0, 0, 5, 0));
    set_config(POL_STATIC, 0, 0, 0);
    send_query(make_query(3, 37, 37, 15, 0, 0, 0, 30, 0, 0));
    set_config(POL_STATIC, 0, 0, 7);
    send_query(make_query(2, 1023, 1023, 15, 0, 0, 140, 0, 15, 0));
  endtask

  // Borrowing: donor quotas, fixed bases, overcommitted reservations.
  task automatic test_borrowing();
    set_config(POL_BORROW, 100, 0, 4);
    send_query(make_query(0, 400, 200, 15, 10, 20, 30, 40, 10, 15));
    send_query(make_query(1, 400, 400, 15, 100, 0, 300, 0, 15, 0));
    send_query(make_query(2, 400, 300, 4, 0, 400, 0, 0, 0, 15));
    set_config(POL_BORROW, 127, 5, 2);
    send_query(make_query(0, 200, 150, 15, 20, 3, 0, 0, 2, 3));
    send_query(make_query(1, 200, 150, 15, 4, 2, 0, 0, 0, 3));
    send_query(make_query(3, 1, 1, 1, 0, 0, 0, 0, 5, 15));
    set_config(POL_BORROW, 0, 1023, 1);
    send_query(make_query(3, 800, 700, 8, 50, 10, 0, 600, 0, 15));
    send_query(make_query(0, 1023, 1023, 15, 1000, 0, 0, 0, 0, 1));
  endtask

  // The spare policy code must follow dynamic rules in every output.
  task automatic test_unused_policy();
    set_config(POL_UNUSED, 50, 0, 3);
    send_query(make_query(0, 100, 50, 1, 25, 3, 4, 5, 0, 15));
    send_query(make_query(2, 64, 3, 9, 1, 1, 1, 1, 9, 6));
  endtask

  // Random queries across a spread of register settings, extremes included.
  task automatic test_random_settings();
    logic [POL_BITS-1:0] pol;
    int unsigned         pct;
    int unsigned         fixed;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 5)
        0:       pol = POL_DYNAMIC;
        1:       pol = POL_STATIC;
        4:       pol = POL_UNUSED;
        default: pol = POL_BORROW;
      endcase
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 100;
        2:       pct = 127;
        default: pct = $urandom_range(0, 127);
      endcase
      case ($urandom_range(0, 3))
        0:       fixed = 0;
        1:       fixed = 1023;
        2:       fixed = $urandom_range(1, 32);
        default: fixed = $urandom_range(0, 1023);
      endcase
      set_config(pol, pct, fixed, $urandom_range(0, 7));
      repeat (170) send_query(random_query());
    end
  endtask

  // Full rate on both sides with borrowing enabled.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    set_config(POL_BORROW, $urandom_range(0, 100), $urandom_range(0, 64), $urandom_range(1, 4));
    repeat (150) send_query(random_query());
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    rst = 1'b1;
    push = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    thread_id = '0;
    class_capacity = '0;
    free_count = '0;
    count_needed = '0;
    used_thread0 = '0;
    used_thread1 = '0;
    used_thread2 = '0;
    used_thread3 = '0;
    donor_mask = '0;
    active_mask = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_static_partition();
    test_borrowing();
    test_unused_policy();
    test_random_settings();
    test_back_to_back();
    drain_pending();

    $display("Sent %0d admission queries and checked %0d results", queries_sent,
             results_checked);
    $display("Covered %0d register settings, all four policy codes, idle and full-rate traffic",
             settings_used);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
